// File: src/nibcpu_pkg.sv
// Shared types and constants for the nibble CPU execute block.
package nibcpu_pkg;

  localparam int RAM_COLS  = 8;
  localparam int RAM_LINES = 16;
  localparam int RAM_DEPTH = RAM_COLS * RAM_LINES;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam logic [3:0] ADX_NO_SKIP_IMM = 4'hA;

  typedef enum logic [4:0] {
    OP_LBL     = 5'd0,
    OP_EXBLA   = 5'd1,
    OP_LAX     = 5'd2,
    OP_LDA     = 5'd3,
    OP_EXC     = 5'd4,
    OP_ADD     = 5'd5,
    OP_ADD11   = 5'd6,
    OP_ADX     = 5'd7,
    OP_COMA    = 5'd8,
    OP_RC      = 5'd9,
    OP_SC      = 5'd10,
    OP_TA      = 5'd11,
    OP_TB      = 5'd12,
    OP_TC      = 5'd13,
    OP_TAM     = 5'd14,
    OP_TIS     = 5'd15,
    OP_TMI     = 5'd16,
    OP_TA0     = 5'd17,
    OP_TABL    = 5'd18,
    OP_RM      = 5'd19,
    OP_SM      = 5'd20,
    OP_CEND    = 5'd21,
    OP_IDIV    = 5'd22,
    OP_ILLEGAL = 5'd23
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] imm_nibble;
    logic [6:0] second_byte;
    logic       alpha_pin;
    logic       beta_pin;
    logic       second_tick;
  } item_t;

  typedef struct packed {
    logic [3:0] acc;
    logic       carry_flag;
    logic [2:0] ptr_col;
    logic [3:0] ptr_line;
    logic       skip_pending;
    logic       lax_run;
    logic       seconds_flag;
  } core_state_t;

  typedef struct packed {
    logic was_skipped;
    logic sleep_request;
    logic divider_clear;
    logic illegal_halt;
  } status_t;

  typedef struct packed {
    logic             we;
    logic [ADDR_W-1:0] addr;
    logic [3:0]       wdata;
  } ram_write_t;

endpackage

// File: src/nibcpu_ram.sv
// Data RAM of the core with per-entry valid bits and a registered read port.
module nibcpu_ram
  import nibcpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  input  ram_write_t        wr,
  output logic [3:0]        rdata
);

  logic [3:0]           mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] entry_valid;
  logic [3:0]           rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (wr.we) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      if (re) begin
        rvalid_q <= entry_valid[raddr];
      end
    end
  end

  assign rdata = rvalid_q ? rdata_q : 4'h0;

endmodule

// File: src/nibcpu_alu.sv
// Instruction execute logic: next core state, RAM write-back and result status.
module nibcpu_alu
  import nibcpu_pkg::*;
(
  input  item_t       item,
  input  core_state_t st,
  input  logic [3:0]  ram_rdata,
  output core_state_t st_next,
  output logic        ram_we,
  output logic [3:0]  ram_wdata,
  output status_t     status
);

  logic [1:0] bit_sel;
  logic [3:0] bit_mask;
  logic [4:0] sum_add;
  logic [4:0] sum_imm;
  logic       sec;
  logic       sk;

  always_comb begin
    bit_sel  = item.imm_nibble[1:0];
    bit_mask = 4'b0001 << bit_sel;
    sum_add  = {1'b0, st.acc} + {1'b0, ram_rdata} + {4'b0000, st.carry_flag};
    sum_imm  = {1'b0, st.acc} + {1'b0, item.imm_nibble};
    sec      = st.seconds_flag | item.second_tick;
    sk       = 1'b0;
    st_next  = st;
    st_next.seconds_flag = sec;
    ram_we    = 1'b0;
    ram_wdata = st.acc;
    status    = '0;

    if (st.lax_run && (item.op == OP_LAX)) begin
      status.was_skipped   = 1'b1;
      st_next.skip_pending = 1'b0;
    end else if (st.skip_pending) begin
      status.was_skipped   = 1'b1;
      st_next.skip_pending = 1'b0;
      st_next.lax_run      = 1'b0;
    end else begin
      st_next.lax_run = 1'b0;
      case (item.op)
        OP_LBL: begin
          st_next.ptr_col  = item.second_byte[6:4];
          st_next.ptr_line = item.second_byte[3:0];
        end
        OP_EXBLA: begin
          st_next.ptr_line = st.acc;
          st_next.acc      = st.ptr_line;
        end
        OP_LAX: begin
          st_next.acc     = item.imm_nibble;
          st_next.lax_run = 1'b1;
        end
        OP_LDA: begin
          st_next.acc     = ram_rdata;
          st_next.ptr_col = st.ptr_col ^ {1'b0, bit_sel};
        end
        OP_EXC: begin
          ram_we          = 1'b1;
          ram_wdata       = st.acc;
          st_next.acc     = ram_rdata;
          st_next.ptr_col = st.ptr_col ^ {1'b0, bit_sel};
        end
        OP_ADD: begin
          st_next.acc = st.acc + ram_rdata;
        end
        OP_ADD11: begin
          st_next.acc        = sum_add[3:0];
          st_next.carry_flag = sum_add[4];
          sk                 = sum_add[4];
        end
        OP_ADX: begin
          st_next.acc = sum_imm[3:0];
          sk          = sum_imm[4] && (item.imm_nibble != ADX_NO_SKIP_IMM);
        end
        OP_COMA:  st_next.acc = ~st.acc;
        OP_RC:    st_next.carry_flag = 1'b0;
        OP_SC:    st_next.carry_flag = 1'b1;
        OP_TA:    sk = item.alpha_pin;
        OP_TB:    sk = item.beta_pin;
        OP_TC:    sk = ~st.carry_flag;
        OP_TAM:   sk = (st.acc == ram_rdata);
        OP_TIS: begin
          sk                   = ~sec;
          st_next.seconds_flag = 1'b0;
        end
        OP_TMI:   sk = ram_rdata[bit_sel];
        OP_TA0:   sk = (st.acc == 4'h0);
        OP_TABL:  sk = (st.acc == st.ptr_line);
        OP_RM: begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~bit_mask;
        end
        OP_SM: begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | bit_mask;
        end
        OP_CEND:  status.sleep_request = 1'b1;
        OP_IDIV:  status.divider_clear = 1'b1;
        default:  status.illegal_halt  = 1'b1;
      endcase
      st_next.skip_pending = sk;
    end
  end

endmodule

// File: src/nibble_cpu_alu_ram_execute.sv
// Top level of the nibble CPU execute block.
//
// Requests arrive on the in channel (in_valid/in_ready), one decoded
// instruction each. Every request produces exactly one result on the out
// channel (out_valid/out_ready) carrying the accumulator, carry and RAM
// pointer after the instruction, plus the skip flag and the three pulses.
// An accepted request reads the data RAM at the current pointer in the same
// edge; once the output register is free, it is executed, writes the RAM back
// and loads the output register. A new request is taken only after the executing
// one has been passed to the output register, limited by the RAM read-execute-write
// loop on the shared pointer.
// The output register lets one request be accepted while the previous result
// still waits. When the receiver stalls longer, the executing request holds
// and in_ready stays low until the result is taken.
// Reset clears the accumulator, carry, pointer, skip and seconds state and
// marks every RAM entry as zero at once; requests are accepted in the first
// cycle after reset.
module nibble_cpu_alu_ram_execute
  import nibcpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] op,
  input  logic [3:0] imm_nibble,
  input  logic [6:0] second_byte,
  input  logic       alpha_pin,
  input  logic       beta_pin,
  input  logic       second_tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] acc_out,
  output logic       carry_out,
  output logic [2:0] ptr_col_out,
  output logic [3:0] ptr_line_out,
  output logic       was_skipped,
  output logic       sleep_request,
  output logic       divider_clear,
  output logic       illegal_halt
);

  item_t       item;
  core_state_t st;
  core_state_t st_next;
  status_t     status;
  ram_write_t  ram_wr;
  logic        exec_valid;
  logic        exec_fire;
  logic        in_fire;
  logic        alu_we;
  logic [3:0]  alu_wdata;
  logic [3:0]  ram_rdata;
  logic [ADDR_W-1:0] ram_addr;

  assign in_ready  = ~exec_valid;
  assign in_fire   = in_valid & in_ready;
  assign exec_fire = exec_valid & (~out_valid | out_ready);
  assign ram_addr  = {st.ptr_col, st.ptr_line};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item.op          <= op_t'(op);
      item.imm_nibble  <= imm_nibble;
      item.second_byte <= second_byte;
      item.alpha_pin   <= alpha_pin;
      item.beta_pin    <= beta_pin;
      item.second_tick <= second_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid <= 1'b0;
      out_valid  <= 1'b0;
      st         <= '0;
    end else begin
      if (in_fire) begin
        exec_valid <= 1'b1;
      end else if (exec_fire) begin
        exec_valid <= 1'b0;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      acc_out       <= st_next.acc;
      carry_out     <= st_next.carry_flag;
      ptr_col_out   <= st_next.ptr_col;
      ptr_line_out  <= st_next.ptr_line;
      was_skipped   <= status.was_skipped;
      sleep_request <= status.sleep_request;
      divider_clear <= status.divider_clear;
      illegal_halt  <= status.illegal_halt;
    end
  end

  assign ram_wr.we    = alu_we & exec_fire;
  assign ram_wr.addr  = ram_addr;
  assign ram_wr.wdata = alu_wdata;

  nibcpu_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (in_fire),
    .raddr (ram_addr),
    .wr    (ram_wr),
    .rdata (ram_rdata)
  );

  nibcpu_alu u_alu (
    .item      (item),
    .st        (st),
    .ram_rdata (ram_rdata),
    .st_next   (st_next),
    .ram_we    (alu_we),
    .ram_wdata (alu_wdata),
    .status    (status)
  );

endmodule

// File: src/nibcpu_checker.sv
// Port-level assertions for the nibble CPU execute block and their binding.
module nibcpu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] acc_out,
  input logic       was_skipped,
  input logic       sleep_request,
  input logic       divider_clear,
  input logic       illegal_halt
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second request was accepted while one was executing.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(acc_out)))
    else $error("A stalled result changed or was dropped.");

  a_skip_no_pulse: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_skipped) |-> (!sleep_request && !divider_clear && !illegal_halt))
    else $error("A skipped request raised a pulse.");

  a_pulse_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({sleep_request, divider_clear, illegal_halt}))
    else $error("More than one pulse on a single result.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("A result was offered right after reset.");

endmodule

bind nibble_cpu_alu_ram_execute nibcpu_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .acc_out       (acc_out),
  .was_skipped   (was_skipped),
  .sleep_request (sleep_request),
  .divider_clear (divider_clear),
  .illegal_halt  (illegal_halt)
);

// File: tb/tb.sv
// Self-checking testbench for the nibble CPU execute block: random and directed requests.
`timescale 1ns / 100ps

module tb;
  import nibcpu_pkg::*;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] imm;
    logic [6:0] sb;
    logic       alpha;
    logic       beta;
    logic       tick;
  } instr_t;

  typedef struct packed {
    logic [3:0] acc;
    logic       carry;
    logic [2:0] col;
    logic [3:0] line;
    status_t    status;
  } core_view_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] op = '0;
  logic [3:0] imm_nibble = '0;
  logic [6:0] second_byte = '0;
  logic       alpha_pin = 1'b0;
  logic       beta_pin = 1'b0;
  logic       second_tick = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] acc_out;
  logic       carry_out;
  logic [2:0] ptr_col_out;
  logic [3:0] ptr_line_out;
  logic       was_skipped;
  logic       sleep_request;
  logic       divider_clear;
  logic       illegal_halt;

  nibble_cpu_alu_ram_execute dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .imm_nibble(imm_nibble),
    .second_byte(second_byte),
    .alpha_pin(alpha_pin),
    .beta_pin(beta_pin),
    .second_tick(second_tick),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .acc_out(acc_out),
    .carry_out(carry_out),
    .ptr_col_out(ptr_col_out),
    .ptr_line_out(ptr_line_out),
    .was_skipped(was_skipped),
    .sleep_request(sleep_request),
    .divider_clear(divider_clear),
    .illegal_halt(illegal_halt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [3:0] core_acc = '0;
  logic       core_carry = 1'b0;
  logic [2:0] core_col = '0;
  logic [3:0] core_line = '0;
  logic       core_skip = 1'b0;
  logic       core_lax_run = 1'b0;
  logic       core_secs = 1'b0;
  logic [3:0] core_ram [RAM_DEPTH];

  instr_t     pending_instrs[$];
  core_view_t awaited_states[$];
  instr_t     offered;
  logic       req_taken = 1'b0;
  int         send_idle_pct = 12;
  int         recv_idle_pct = 52;
  int         stalls_asked = 0;
  int         stalls_begun = 0;
  int         stall_left = 0;
  int         failures = 0;
  int         reported = 0;

  function automatic core_view_t run_instruction(instr_t ins);
    core_view_t      r;
    logic [1:0]      bsel;
    logic [ADDR_W-1:0] addr;
    logic [3:0]      mem;
    logic [3:0]      tmp;
    logic [4:0]      sum;
    logic            sk;
    r = '0;
    bsel = ins.imm[1:0];
    addr = {core_col, core_line};
    mem = core_ram[addr];
    sk = 1'b0;
    if (ins.tick) core_secs = 1'b1;
    if (core_lax_run && ins.op == OP_LAX) begin
      r.status.was_skipped = 1'b1;
      core_skip = 1'b0;
    end else if (core_skip) begin
      r.status.was_skipped = 1'b1;
      core_skip = 1'b0;
      core_lax_run = 1'b0;
    end else begin
      core_lax_run = 1'b0;
      case (ins.op)
        OP_LBL: {core_col, core_line} = ins.sb;
        OP_EXBLA: begin
          tmp = core_line;
          core_line = core_acc;
          core_acc = tmp;
        end
        OP_LAX: begin
          core_acc = ins.imm;
          core_lax_run = 1'b1;
        end
        OP_LDA: begin
          core_acc = mem;
          core_col = core_col ^ {1'b0, bsel};
        end
        OP_EXC: begin
          core_ram[addr] = core_acc;
          core_acc = mem;
          core_col = core_col ^ {1'b0, bsel};
        end
        OP_ADD: core_acc = core_acc + mem;
        OP_ADD11: begin
          sum = {1'b0, core_acc} + {1'b0, mem} + {4'b0000, core_carry};
          core_carry = sum[4];
          sk = sum[4];
          core_acc = sum[3:0];
        end
        OP_ADX: begin
          sum = {1'b0, core_acc} + {1'b0, ins.imm};
          sk = sum[4] && (ins.imm != ADX_NO_SKIP_IMM);
          core_acc = sum[3:0];
        end
        OP_COMA: core_acc = ~core_acc;
        OP_RC: core_carry = 1'b0;
        OP_SC: core_carry = 1'b1;
        OP_TA: sk = ins.alpha;
        OP_TB: sk = ins.beta;
        OP_TC: sk = !core_carry;
        OP_TAM: sk = (core_acc == mem);
        OP_TIS: begin
          sk = !core_secs;
          core_secs = 1'b0;
        end
        OP_TMI: sk = mem[bsel];
        OP_TA0: sk = (core_acc == 4'd0);
        OP_TABL: sk = (core_acc == core_line);
        OP_RM: core_ram[addr] = mem & ~(4'b0001 << bsel);
        OP_SM: core_ram[addr] = mem | (4'b0001 << bsel);
        OP_CEND: r.status.sleep_request = 1'b1;
        OP_IDIV: r.status.divider_clear = 1'b1;
        default: r.status.illegal_halt = 1'b1;
      endcase
      core_skip = sk;
    end
    r.acc = core_acc;
    r.carry = core_carry;
    r.col = core_col;
    r.line = core_line;
    return r;
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    int     pick;
    pick = $urandom_range(99);
    if (pick < 10) ins.op = OP_LBL;
    else if (pick < 18) ins.op = 5'($urandom_range(31, OP_ILLEGAL));
    else ins.op = 5'($urandom_range(OP_IDIV, OP_EXBLA));
    ins.imm = 4'($urandom);
    ins.sb = 7'($urandom);
    ins.alpha = 1'($urandom);
    ins.beta = 1'($urandom);
    ins.tick = ($urandom_range(99) < 15);
    return ins;
  endfunction

  task automatic push_instr(input logic [4:0] o, input logic [3:0] i, input logic [6:0] s,
                            input logic a, input logic b, input logic t);
    instr_t ins;
    ins = '{o, i, s, a, b, t};
    pending_instrs.push_back(ins);
  endtask

  // Runs of immediate loads are mixed in so that the skip-after-load rule is exercised.
  task automatic push_random_phase(input int count);
    int     n;
    int     k;
    instr_t ins;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 6) begin
        k = $urandom_range(4, 2);
        repeat (k) begin
          ins = random_instr();
          ins.op = OP_LAX;
          pending_instrs.push_back(ins);
        end
        n += k;
      end else begin
        pending_instrs.push_back(random_instr());
        n++;
      end
    end
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_instrs.size() != 0 || in_valid || awaited_states.size() != 0);
  endtask

  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_instrs.pop_front();
        op <= offered.op;
        imm_nibble <= offered.imm;
        second_byte <= offered.sb;
        alpha_pin <= offered.alpha;
        beta_pin <= offered.beta;
        second_tick <= offered.tick;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      awaited_states.push_back(run_instruction(offered));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stalls_begun != stalls_asked) begin
      stalls_begun <= stalls_begun + 1;
      stall_left <= 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    core_view_t seen;
    core_view_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      seen = {acc_out, carry_out, ptr_col_out, ptr_line_out,
              was_skipped, sleep_request, divider_clear, illegal_halt};
      if (awaited_states.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected result at %0t: acc=%h c=%b col=%h line=%h st=%b",
                   $realtime, seen.acc, seen.carry, seen.col, seen.line, seen.status);
        end
      end else begin
        want = awaited_states.pop_front();
        if (seen !== want) begin
          failures++;
          if (reported < 10) begin
            reported++;
            $display("Mismatch at %0t: expected acc=%h c=%b col=%h line=%h st=%b",
                     $realtime, want.acc, want.carry, want.col, want.line, want.status);
            $display("                  got      acc=%h c=%b col=%h line=%h st=%b",
                     seen.acc, seen.carry, seen.col, seen.line, seen.status);
          end
        end
      end
    end
  end

  initial begin
    foreach (core_ram[k]) core_ram[k] = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    push_instr(OP_LBL,     4'h0, 7'h7F, 1'b0, 1'b0, 1'b0);
    push_instr(OP_SM,      4'hF, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_TMI,     4'h3, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_CEND,    4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_RM,      4'h3, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_LAX,     4'hF, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_LAX,     4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_ADX,     ADX_NO_SKIP_IMM, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_ADX,     4'h7, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_ILLEGAL, 4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_COMA,    4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_EXC,     4'h3, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_LDA,     4'h3, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_ADD,     4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_SC,      4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_ADD11,   4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_IDIV,    4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_RC,      4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_TC,      4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_TA,      4'h0, 7'h00, 1'b1, 1'b0, 1'b0);
    push_instr(OP_TB,      4'h0, 7'h00, 1'b0, 1'b1, 1'b1);
    push_instr(OP_TIS,     4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_EXBLA,   4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_TABL,    4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_TAM,     4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_TA0,     4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(5'd31,      4'h0, 7'h00, 1'b0, 1'b0, 1'b0);
    push_instr(OP_LBL,     4'h0, 7'h00, 1'b0, 1'b0, 1'b0);

    push_random_phase(420);
    wait_until_drained();

    send_idle_pct = 52;
    recv_idle_pct = 12;
    push_random_phase(430);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stalls_asked = 1;
    push_random_phase(430);
    wait_until_drained();

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
